/* hw/rtl/debug_link_framer_with_timeout_core_assert.svh */
// ----------------------------------------------------------------------------
// Debug link framer assertion macros
// Shared concurrent assertion forms for the debug link framer checkers.
// ----------------------------------------------------------------------------
`ifndef DEBUG_LINK_FRAMER_WITH_TIMEOUT_CORE_ASSERT_SVH
`define DEBUG_LINK_FRAMER_WITH_TIMEOUT_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DLF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("debug link framer: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DLF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("debug link framer: assertion failed");

`endif

/* hw/rtl/dlf_pkg.sv */
// ----------------------------------------------------------------------------
// Debug link framer package
// Transaction types, job format, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package dlf_pkg;

  // Input transaction.
  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx_byte;
    logic        rx_last;
    logic [31:0] sender_ip;
    logic [15:0] sender_port;
    logic [31:0] fault_status;
    logic        link_up;
  } in_item_t;

  // Output transaction.
  typedef struct packed {
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [1:0]  rx_status;
  } out_item_t;

  // Input item kinds.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // Output item kinds.
  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  // Receive verdicts.
  typedef enum logic [1:0] {
    RX_SHORT = 2'd0,
    RX_BAD   = 2'd1,
    RX_OK    = 2'd2,
    RX_CLEAR = 2'd3
  } rx_status_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ID           = 3'd0,
    CFG_PEER_ID          = 3'd1,
    CFG_TELEMETRY_CODE   = 3'd2,
    CFG_CLEAR_FAULT_CODE = 3'd3,
    CFG_DISCONNECT_LIMIT = 3'd4,
    CFG_DEFAULT_IP       = 3'd5,
    CFG_DEFAULT_PORT     = 3'd6
  } cfg_idx_e;

  // Register reset values.
  localparam logic [7:0]  CLEAR_FAULT_RST = 8'd1;
  localparam logic [15:0] DISC_LIMIT_RST  = 16'd50;
  localparam logic [31:0] DEFAULT_IP_RST  = 32'hC0A8_C864;
  localparam logic [15:0] DEFAULT_PORT_RST = 16'd0;

  // Packet and frame geometry.
  localparam int unsigned    RX_MIN_LEN  = 14;
  localparam logic [15:0]    RX_LEN_MAX  = 16'hFFFF;
  localparam logic [15:0]    RX_CODE_POS = 16'd6;
  localparam logic [15:0]    RX_SHORT_BELOW = 16'(RX_MIN_LEN - 1);
  localparam int unsigned    FRAME_LEN   = 34;
  localparam int unsigned    IDX_W       = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_SUM_LO  = IDX_W'(FRAME_LEN - 2);

  // Configuration values used by the front and back.
  typedef struct packed {
    logic [7:0]  own_id;
    logic [7:0]  peer_id;
    logic [7:0]  telemetry_code;
    logic [7:0]  clear_fault_code;
    logic [15:0] disconnect_limit;
  } cfg_t;

  // Configuration write as seen by the front.
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
  } cfg_wr_t;

  // Job passed from front to back.
  typedef struct packed {
    logic        kind;
    rx_status_e  status;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [31:0] tick;
    logic [31:0] fault;
  } job_t;

endpackage

/* hw/rtl/dlf_front.sv */
// ----------------------------------------------------------------------------
// Debug link framer front end
// Accepts ticks and packet bytes, keeps link state and issues jobs.
// ----------------------------------------------------------------------------
module dlf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dlf_pkg::cfg_t    cfg_i,
  input  dlf_pkg::cfg_wr_t cfg_wr_i,
  input  logic             accept_i,
  input  dlf_pkg::in_item_t item_i,
  output logic             push_o,
  output dlf_pkg::job_t    job_o
);
  import dlf_pkg::*;

  logic        active_q, active_d;
  logic [15:0] silence_q, silence_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] tip_q, tip_d;
  logic [15:0] tport_q, tport_d;
  logic [15:0] len_q, len_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  prev_q, prev_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  code_eff;
  logic [15:0] silence_inc;

  // Item handling and register writes to the target.
  always_comb begin
    active_d  = active_q;
    silence_d = silence_q;
    tick_d    = tick_q;
    tip_d     = tip_q;
    tport_d   = tport_q;
    len_d     = len_q;
    sum_d     = sum_q;
    prev_d    = prev_q;
    code_d    = code_q;
    push_o    = 1'b0;
    job_o     = '0;
    code_eff  = (len_q == RX_CODE_POS) ? item_i.rx_byte : code_q;
    silence_inc = silence_q + 16'd1;

    if (accept_i) begin
      if (item_i.cmd == CMD_BYTE) begin
        if (!item_i.rx_last) begin
          sum_d  = sum_q + {8'h00, prev_q};
          prev_d = item_i.rx_byte;
          code_d = code_eff;
          if (len_q != RX_LEN_MAX) begin
            len_d = len_q + 16'd1;
          end
        end else begin
          // Last byte: give the verdict and restart the accumulators.
          len_d      = '0;
          sum_d      = '0;
          prev_d     = '0;
          code_d     = '0;
          push_o     = 1'b1;
          job_o.kind = KIND_RX;
          if (len_q < RX_SHORT_BELOW) begin
            job_o.status = RX_SHORT;
          end else begin
            active_d  = 1'b1;
            silence_d = '0;
            tip_d     = item_i.sender_ip;
            tport_d   = item_i.sender_port;
            if ({item_i.rx_byte, prev_q} != sum_q) begin
              job_o.status = RX_BAD;
            end else if (code_eff == cfg_i.clear_fault_code) begin
              job_o.status = RX_CLEAR;
            end else begin
              job_o.status = RX_OK;
            end
          end
          job_o.dest_ip   = tip_d;
          job_o.dest_port = tport_d;
        end
      end else if (item_i.link_up) begin
        tick_d = tick_q + 32'd1;
        if (active_q) begin
          if (silence_inc >= cfg_i.disconnect_limit) begin
            active_d  = 1'b0;
            silence_d = '0;
          end else begin
            silence_d       = silence_inc;
            push_o          = 1'b1;
            job_o.kind      = KIND_TX;
            job_o.status    = RX_SHORT;
            job_o.dest_ip   = tip_q;
            job_o.dest_port = tport_q;
            job_o.tick      = tick_d;
            job_o.fault     = item_i.fault_status;
          end
        end
      end
    end

    // Writing a default also loads the live target.
    if (cfg_wr_i.we) begin
      case (cfg_wr_i.idx)
        CFG_DEFAULT_IP:   tip_d   = cfg_wr_i.data;
        CFG_DEFAULT_PORT: tport_d = cfg_wr_i.data[15:0];
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      silence_q <= '0;
      tick_q    <= '0;
      tip_q     <= DEFAULT_IP_RST;
      tport_q   <= DEFAULT_PORT_RST;
      len_q     <= '0;
      sum_q     <= '0;
      prev_q    <= '0;
      code_q    <= '0;
    end else begin
      active_q  <= active_d;
      silence_q <= silence_d;
      tick_q    <= tick_d;
      tip_q     <= tip_d;
      tport_q   <= tport_d;
      len_q     <= len_d;
      sum_q     <= sum_d;
      prev_q    <= prev_d;
      code_q    <= code_d;
    end
  end

endmodule

/* hw/rtl/dlf_queue.sv */
// ----------------------------------------------------------------------------
// Debug link framer job queue
// Small first-in first-out buffer of jobs between front and back.
// ----------------------------------------------------------------------------
module dlf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dlf_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dlf_pkg::job_t data_o
);
  import dlf_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/dlf_back.sv */
// ----------------------------------------------------------------------------
// Debug link framer back end
// Turns jobs into verdicts or telemetry frame bytes behind an output register.
// ----------------------------------------------------------------------------
module dlf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dlf_pkg::cfg_t      cfg_i,
  input  logic               head_valid_i,
  input  dlf_pkg::job_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dlf_pkg::out_item_t out_data_o
);
  import dlf_pkg::*;

  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       frame_byte;
  logic             load;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign load        = !out_valid_q || !out_stall_i;

  // Frame byte at the current offset.
  always_comb begin
    case (idx_q)
      6'd4:  frame_byte = cfg_i.own_id;
      6'd5:  frame_byte = cfg_i.peer_id;
      6'd6:  frame_byte = cfg_i.telemetry_code;
      6'd7:  frame_byte = 8'hFF;
      6'd9:  frame_byte = 8'h01;
      6'd10: frame_byte = 8'd20;
      6'd12: frame_byte = head_i.tick[7:0];
      6'd13: frame_byte = head_i.tick[15:8];
      6'd14: frame_byte = head_i.tick[23:16];
      6'd15: frame_byte = head_i.tick[31:24];
      6'd28: frame_byte = head_i.fault[7:0];
      6'd29: frame_byte = head_i.fault[15:8];
      6'd30: frame_byte = head_i.fault[23:16];
      6'd31: frame_byte = head_i.fault[31:24];
      6'd32: frame_byte = sum_q[7:0];
      6'd33: frame_byte = sum_q[15:8];
      default: frame_byte = 8'h00;
    endcase
  end

  // Output loading and frame sequencing.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d     = head_valid_i;
      out_d.dest_ip   = head_i.dest_ip;
      out_d.dest_port = head_i.dest_port;
      if (head_valid_i) begin
        if (head_i.kind == KIND_RX) begin
          out_d.out_kind  = KIND_RX;
          out_d.tx_byte   = 8'h00;
          out_d.tx_last   = 1'b0;
          out_d.rx_status = head_i.status;
          pop_o           = 1'b1;
        end else begin
          out_d.out_kind  = KIND_TX;
          out_d.tx_byte   = frame_byte;
          out_d.tx_last   = (idx_q == IDX_LAST);
          out_d.rx_status = RX_SHORT;
          // The running sum covers every byte ahead of the trailer.
          if (idx_q == '0) begin
            sum_d = {8'h00, frame_byte};
          end else if (idx_q < IDX_SUM_LO) begin
            sum_d = sum_q + {8'h00, frame_byte};
          end
          if (idx_q == IDX_LAST) begin
            idx_d = '0;
            pop_o = 1'b1;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sum_q <= sum_d;
  end

endmodule

/* hw/rtl/debug_link_framer_with_timeout_core.sv */
// ----------------------------------------------------------------------------
// Debug link framer with timeout
// Top level: configuration registers, front end, job queue and back end.
// ----------------------------------------------------------------------------
// The input channel carries ticks and received packet bytes; a transaction is
// taken when in_valid_i is high and in_stall_o is low. One item is accepted
// per cycle as long as the job queue has room.
// The output channel carries receive verdicts and telemetry frame bytes under
// the same valid/stall rule, one transaction per cycle at most.
// A last packet byte yields one verdict; a tick with link_up on an active link
// that stays below the disconnect limit yields a 34-byte frame, which the back
// end sends byte by byte. An accepted item's job is written to the queue, then
// loaded into the output register. While a frame is sent, the queue still takes
// new jobs as long as it has room; bytes without a verdict cost nothing at the
// output.
// When the receiver stalls, the output register holds, the queue fills and
// in_stall_o rises once it is full.
// Reset clears the link state, the receive accumulators, the queue and the
// output valid flag, and restores the register defaults.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i.
// ----------------------------------------------------------------------------
module debug_link_framer_with_timeout_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  dlf_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output dlf_pkg::out_item_t               out_data_o
);
  import dlf_pkg::*;

  cfg_t    cfg_q;
  cfg_wr_t cfg_wr;
  logic    q_full, q_push, q_pop, q_valid, accept;
  job_t    push_job, head_job;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_wdata_i;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id           <= '0;
      cfg_q.peer_id          <= '0;
      cfg_q.telemetry_code   <= '0;
      cfg_q.clear_fault_code <= CLEAR_FAULT_RST;
      cfg_q.disconnect_limit <= DISC_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_ID:           cfg_q.own_id           <= cfg_wdata_i[7:0];
        CFG_PEER_ID:          cfg_q.peer_id          <= cfg_wdata_i[7:0];
        CFG_TELEMETRY_CODE:   cfg_q.telemetry_code   <= cfg_wdata_i[7:0];
        CFG_CLEAR_FAULT_CODE: cfg_q.clear_fault_code <= cfg_wdata_i[7:0];
        CFG_DISCONNECT_LIMIT: cfg_q.disconnect_limit <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Front end: classification and link state.
  dlf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cfg_wr_i (cfg_wr),
    .accept_i (accept),
    .item_i   (in_data_i),
    .push_o   (q_push),
    .job_o    (push_job)
  );

  // Job queue between the two halves.
  dlf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (head_job)
  );

  // Back end: verdicts and frame serialisation.
  dlf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (q_valid),
    .head_i       (head_job),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

/* hw/rtl/dlf_checker.sv */
// ----------------------------------------------------------------------------
// Debug link framer checker
// Port-level assertions on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "debug_link_framer_with_timeout_core_assert.svh"

module dlf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dlf_pkg::out_item_t out_data_o
);
  import dlf_pkg::*;

  // A stalled transaction is held unchanged.
  `DLF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // A verdict carries no frame byte, and a frame byte carries no verdict.
  `DLF_ASSERT_IMPL(a_kind_clean, out_valid_o, (out_data_o.out_kind == KIND_RX) ? (out_data_o.tx_byte == 8'h00 && !out_data_o.tx_last) : (out_data_o.rx_status == RX_SHORT))

  // Inside a frame the next byte follows at once, to the same target.
  `DLF_ASSERT_NEXT(a_frame_cont, out_valid_o && !out_stall_i && out_data_o.out_kind == KIND_TX && !out_data_o.tx_last, out_valid_o && out_data_o.out_kind == KIND_TX && out_data_o.dest_ip == $past(out_data_o.dest_ip) && out_data_o.dest_port == $past(out_data_o.dest_port))

endmodule

bind debug_link_framer_with_timeout_core dlf_checker u_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debug link framer testbench
// Sends ticks and received packet bytes through the valid/stall input channel.
// Each accepted transaction is run through an in-bench copy of the link and
// framing behaviour, and every output transaction is checked field by field
// against the oldest result still owed. A directed table comes first, then
// extreme register settings, a back-pressure episode and random traffic.
// ----------------------------------------------------------------------------
module tb;
  import dlf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;
  localparam logic [7:0]  FRM_MARKER    = 8'hFF;
  localparam logic [7:0]  FRM_VERSION   = 8'h01;
  localparam logic [7:0]  FRM_BODY_LEN  = 8'd20;
  localparam int          FILL_RANDOM   = -1;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned PHASE_ITEMS   = 12;
  localparam int unsigned RAND_PHASES   = 2;
  localparam int unsigned RAND_MAX_LEN  = 18;
  localparam int unsigned DIR_ROWS      = 11;

  typedef enum logic {
    ROW_TICK,
    ROW_PACKET
  } row_op_e;

  // One line of the directed table; the verdict is pinned where pin is set.
  typedef struct packed {
    row_op_e     op;
    int unsigned len;
    logic [7:0]  code;
    bit          bad;
    int          fill;
    logic [31:0] ip;
    logic [15:0] port;
    logic        up;
    logic [31:0] fault;
    bit          pin;
    rx_status_e  want;
  } dir_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [31:0]          cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;

  // Bench copy of the registers and the link state.
  logic [7:0]  m_own, m_peer, m_tcode, m_clr;
  logic [15:0] m_limit;
  logic        m_active;
  logic [15:0] m_silence;
  logic [31:0] m_ticks;
  logic [31:0] m_tip;
  logic [15:0] m_tport;
  logic [15:0] m_rx_len, m_rx_sum;
  logic [7:0]  m_rx_prev, m_rx_code;

  out_item_t owed_out[$];
  dir_row_t  dir_tab [DIR_ROWS];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;

  int unsigned n_fail     = 0;
  int unsigned n_items    = 0;
  int unsigned n_verdicts = 0;
  int unsigned n_frames   = 0;
  int unsigned n_writes   = 0;
  int unsigned n_checked  = 0;

  debug_link_framer_with_timeout_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Register and link state as left by reset.
  task automatic reset_link_copy();
    m_own     = '0;
    m_peer    = '0;
    m_tcode   = '0;
    m_clr     = CLEAR_FAULT_RST;
    m_limit   = DISC_LIMIT_RST;
    m_active  = 1'b0;
    m_silence = '0;
    m_ticks   = '0;
    m_tip     = DEFAULT_IP_RST;
    m_tport   = DEFAULT_PORT_RST;
    m_rx_len  = '0;
    m_rx_sum  = '0;
    m_rx_prev = '0;
    m_rx_code = '0;
  endtask

  // Advance the link by one accepted transaction and queue what it owes.
  task automatic step_link(input in_item_t it, input bit pin, input rx_status_e want);
    logic [15:0] len;
    logic [15:0] trailer;
    logic [15:0] fsum;
    logic [7:0]  f [FRAME_LEN];
    rx_status_e  st;
    out_item_t   o;
    int          k;
    if (it.cmd == CMD_BYTE) begin
      if (m_rx_len == RX_CODE_POS) m_rx_code = it.rx_byte;
      if (!it.rx_last) begin
        // The sum trails by two bytes so that the trailer stays out of it.
        m_rx_sum  = m_rx_sum + 16'(m_rx_prev);
        m_rx_prev = it.rx_byte;
        if (m_rx_len != RX_LEN_MAX) m_rx_len = m_rx_len + 16'd1;
      end else begin
        len     = (m_rx_len != RX_LEN_MAX) ? m_rx_len + 16'd1 : RX_LEN_MAX;
        trailer = {it.rx_byte, m_rx_prev};
        if (32'(len) < RX_MIN_LEN) begin
          st = RX_SHORT;
        end else begin
          // The sender is captured before the checksum is looked at.
          m_active  = 1'b1;
          m_silence = '0;
          m_tip     = it.sender_ip;
          m_tport   = it.sender_port;
          if (trailer != m_rx_sum) st = RX_BAD;
          else if (m_rx_code == m_clr) st = RX_CLEAR;
          else st = RX_OK;
        end
        m_rx_len  = '0;
        m_rx_sum  = '0;
        m_rx_prev = '0;
        m_rx_code = '0;
        o           = '0;
        o.out_kind  = KIND_RX;
        o.dest_ip   = m_tip;
        o.dest_port = m_tport;
        o.rx_status = pin ? want : st;
        owed_out.push_back(o);
        n_verdicts++;
      end
    end else if (it.link_up) begin
      m_ticks = m_ticks + 32'd1;
      if (m_active) begin
        m_silence = m_silence + 16'd1;
        if (m_silence >= m_limit) begin
          // The tick that reaches the limit drops the link and sends nothing.
          m_active  = 1'b0;
          m_silence = '0;
        end else begin
          for (k = 0; k < FRAME_LEN; k++) f[k] = '0;
          f[4]  = m_own;
          f[5]  = m_peer;
          f[6]  = m_tcode;
          f[7]  = FRM_MARKER;
          f[9]  = FRM_VERSION;
          f[10] = FRM_BODY_LEN;
          for (k = 0; k < 4; k++) begin
            f[12 + k] = 8'(m_ticks >> (8 * k));
            f[28 + k] = 8'(it.fault_status >> (8 * k));
          end
          fsum = '0;
          for (k = 0; k < FRAME_LEN - 2; k++) fsum = fsum + 16'(f[k]);
          f[FRAME_LEN - 2] = fsum[7:0];
          f[FRAME_LEN - 1] = fsum[15:8];
          for (k = 0; k < FRAME_LEN; k++) begin
            o           = '0;
            o.out_kind  = KIND_TX;
            o.tx_byte   = f[k];
            o.tx_last   = (k == FRAME_LEN - 1);
            o.dest_ip   = m_tip;
            o.dest_port = m_tport;
            owed_out.push_back(o);
          end
          n_frames++;
        end
      end
    end
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    it.cmd          = 1'($urandom_range(0, 1));
    it.rx_byte      = 8'($urandom());
    it.rx_last      = 1'($urandom_range(0, 1));
    it.sender_ip    = $urandom();
    it.sender_port  = 16'($urandom());
    it.fault_status = $urandom();
    it.link_up      = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Offer one transaction, optionally after a random gap, and wait for it to go.
  task automatic send_item(input in_item_t it, input bit pin, input rx_status_e want);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    step_link(it, pin, want);
    n_items++;
  endtask

  task automatic send_tick(input logic up, input logic [31:0] fault);
    in_item_t it;
    it              = rand_item();
    it.cmd          = CMD_TICK;
    it.link_up      = up;
    it.fault_status = fault;
    send_item(it, 1'b0, RX_SHORT);
  endtask

  // Send a packet byte by byte with the trailer built from the running sum.
  // With mixed set, stray ticks may fall between the bytes.
  task automatic send_packet(input int unsigned len, input logic [7:0] code, input bit bad,
                             input int fill, input logic [31:0] ip, input logic [15:0] port,
                             input bit pin, input rx_status_e want, input bit mixed);
    logic [15:0] sum;
    logic [7:0]  b;
    in_item_t    it;
    int unsigned i;
    sum = '0;
    for (i = 0; i < len; i++) begin
      if (len >= RX_MIN_LEN && i == len - 2) b = sum[7:0] ^ 8'(bad);
      else if (len >= RX_MIN_LEN && i == len - 1) b = sum[15:8];
      else if (i == 32'(RX_CODE_POS)) b = code;
      else if (fill == FILL_RANDOM) b = 8'($urandom());
      else b = fill[7:0];
      if (i + 2 < len) sum = sum + 16'(b);
      it         = rand_item();
      it.cmd     = CMD_BYTE;
      it.rx_byte = b;
      it.rx_last = (i == len - 1);
      if (it.rx_last) begin
        it.sender_ip   = ip;
        it.sender_port = port;
      end
      send_item(it, pin, want);
      if (mixed && !it.rx_last && $urandom_range(0, 39) == 0)
        send_tick(1'($urandom_range(0, 1)), $urandom());
    end
  endtask

  // Let the block run dry: wait until nothing is owed, then idle for silent work.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (owed_out.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_OWN_ID:           m_own   = val[7:0];
      CFG_PEER_ID:          m_peer  = val[7:0];
      CFG_TELEMETRY_CODE:   m_tcode = val[7:0];
      CFG_CLEAR_FAULT_CODE: m_clr   = val[7:0];
      CFG_DISCONNECT_LIMIT: m_limit = val[15:0];
      CFG_DEFAULT_IP:       m_tip   = val;
      CFG_DEFAULT_PORT:     m_tport = val[15:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk_i);
  endtask

  // Write every register; unused upper data bits carry junk.
  task automatic apply_settings(input logic [7:0] own, input logic [7:0] peer,
                                input logic [7:0] tcode, input logic [7:0] clr,
                                input logic [15:0] limit, input logic [31:0] ip,
                                input logic [15:0] port);
    write_reg(CFG_OWN_ID,           {24'($urandom()), own});
    write_reg(CFG_PEER_ID,          {24'($urandom()), peer});
    write_reg(CFG_TELEMETRY_CODE,   {24'($urandom()), tcode});
    write_reg(CFG_CLEAR_FAULT_CODE, {24'($urandom()), clr});
    write_reg(CFG_DISCONNECT_LIMIT, {16'($urandom()), limit});
    write_reg(CFG_DEFAULT_IP,       ip);
    write_reg(CFG_DEFAULT_PORT,     {16'($urandom()), port});
  endtask

  // Mostly well-formed packets, with ticks, bad checksums and short packets.
  task automatic random_event();
    int unsigned pick;
    logic [7:0]  code;
    pick = $urandom_range(0, 9);
    code = ($urandom_range(0, 2) == 0) ? m_clr : 8'($urandom());
    if (pick <= 4)
      send_packet($urandom_range(RX_MIN_LEN, RAND_MAX_LEN), code, 1'b0, FILL_RANDOM,
                  $urandom(), 16'($urandom()), 1'b0, RX_SHORT, 1'b1);
    else if (pick == 5)
      send_packet($urandom_range(RX_MIN_LEN, RAND_MAX_LEN), code, 1'b1, FILL_RANDOM,
                  $urandom(), 16'($urandom()), 1'b0, RX_SHORT, 1'b1);
    else if (pick == 6)
      send_packet($urandom_range(1, RX_MIN_LEN - 1), code, 1'b0, FILL_RANDOM, $urandom(),
                  16'($urandom()), 1'b0, RX_SHORT, 1'b1);
    else
      send_tick(($urandom_range(0, 5) != 0), $urandom());
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Compare every output transaction with the oldest one owed.
  always @(posedge clk_i) begin
    out_item_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_out.size() == 0) begin
        $error("output transaction with nothing owed: %h", out_data_o);
        n_fail++;
      end else begin
        due = owed_out.pop_front();
        check_field("out_kind",  32'(due.out_kind),  32'(out_data_o.out_kind));
        check_field("tx_byte",   32'(due.tx_byte),   32'(out_data_o.tx_byte));
        check_field("tx_last",   32'(due.tx_last),   32'(out_data_o.tx_last));
        check_field("dest_ip",   due.dest_ip,        out_data_o.dest_ip);
        check_field("dest_port", 32'(due.dest_port), 32'(out_data_o.dest_port));
        check_field("rx_status", 32'(due.rx_status), 32'(out_data_o.rx_status));
        n_checked++;
      end
    end
  end

  // Receiver: random stall bursts, or one long hold-off when asked for.
  initial begin : receiver
    int unsigned burst;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    dir_row_t    row;
    int unsigned first;
    // Directed table: op, len, code, bad, fill, ip, port, up, fault, pin, want.
    dir_tab[0]  = '{ROW_TICK, 32'd0, 8'h00, 1'b0, 0, 32'h0, 16'h0, 1'b0, 32'h0,
                    1'b0, RX_SHORT};
    dir_tab[1]  = '{ROW_TICK, 32'd0, 8'h00, 1'b0, 0, 32'h0, 16'h0, 1'b1, 32'h0,
                    1'b0, RX_SHORT};
    dir_tab[2]  = '{ROW_PACKET, 32'd1, 8'h00, 1'b0, FILL_RANDOM, 32'h1122_3344, 16'h5566,
                    1'b0, 32'h0, 1'b1, RX_SHORT};
    dir_tab[3]  = '{ROW_PACKET, 32'd13, 8'h01, 1'b0, FILL_RANDOM, 32'hFFFF_FFFF, 16'hFFFF,
                    1'b0, 32'h0, 1'b1, RX_SHORT};
    dir_tab[4]  = '{ROW_PACKET, 32'd14, 8'h02, 1'b0, FILL_RANDOM, 32'hFFFF_FFFF, 16'hFFFF,
                    1'b0, 32'h0, 1'b1, RX_OK};
    dir_tab[5]  = '{ROW_PACKET, 32'd14, 8'h00, 1'b1, 32'hFF, 32'h0, 16'h0,
                    1'b0, 32'h0, 1'b1, RX_BAD};
    dir_tab[6]  = '{ROW_TICK, 32'd0, 8'h00, 1'b0, 0, 32'h0, 16'h0, 1'b1, 32'hFFFF_FFFF,
                    1'b0, RX_SHORT};
    dir_tab[7]  = '{ROW_TICK, 32'd0, 8'h00, 1'b0, 0, 32'h0, 16'h0, 1'b1, 32'h0,
                    1'b0, RX_SHORT};
    dir_tab[8]  = '{ROW_TICK, 32'd0, 8'h00, 1'b0, 0, 32'h0, 16'h0, 1'b0, 32'hFFFF_FFFF,
                    1'b0, RX_SHORT};
    dir_tab[9]  = '{ROW_PACKET, 32'd2, 8'h00, 1'b0, FILL_RANDOM, 32'h0, 16'h0,
                    1'b0, 32'h0, 1'b1, RX_SHORT};
    dir_tab[10] = '{ROW_TICK, 32'd0, 8'h00, 1'b0, 0, 32'h0, 16'h0, 1'b1, 32'h1234_5678,
                    1'b0, RX_SHORT};

    reset_link_copy();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset settings.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_tab[r];
      if (row.op == ROW_TICK)
        send_tick(row.up, row.fault);
      else
        send_packet(row.len, row.code, row.bad, row.fill, row.ip, row.port,
                    row.pin, row.want, 1'b0);
    end

    // Extreme register settings, including limits of one and zero.
    for (int s = 0; s < 3; s++) begin
      drain_block();
      case (s)
        0: begin
          apply_settings(8'hFF, 8'h00, 8'hFF, 8'hFF, 16'd1, 32'h0, 16'hFFFF);
          write_reg(CFG_IDX_NONE, $urandom());
        end
        1: apply_settings(8'h00, 8'hFF, 8'h00, 8'h00, 16'd0, 32'hFFFF_FFFF, 16'h0000);
        default: apply_settings(8'($urandom()), 8'($urandom()), 8'($urandom()),
                                8'($urandom()), 16'hFFFF, $urandom(), 16'($urandom()));
      endcase
      // A short packet first shows the freshly loaded default target.
      send_packet(3, 8'h00, 1'b0, FILL_RANDOM, $urandom(), 16'($urandom()),
                  1'b1, RX_SHORT, 1'b0);
      send_packet(RX_MIN_LEN, m_clr, 1'b0, FILL_RANDOM, $urandom(), 16'($urandom()),
                  1'b1, RX_CLEAR, 1'b0);
      send_tick(1'b1, $urandom());
      send_tick(1'b1, $urandom());
    end

    // Back-pressure: the receiver holds off while ticks keep coming, so the
    // queue fills and the input stalls; then the sender waits for all output.
    hold_req = 1'b1;
    repeat (8) send_tick(1'b1, $urandom());
    drain_block();

    // Random traffic under random settings; the last phase runs flat out.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES - 1) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      drain_block();
      apply_settings(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                     16'($urandom_range(2, 12)), $urandom(), 16'($urandom()));
      first = n_items;
      while (n_items - first < PHASE_ITEMS) random_event();
    end

    drain_block();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d input transactions, %0d register writes, %0d checked outputs.",
             n_items, n_writes, n_checked);
    $display("That includes %0d receive verdicts and %0d telemetry frames.",
             n_verdicts, n_frames);
    if (n_fail == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/dlf_pkg.sv
hw/rtl/dlf_front.sv
hw/rtl/dlf_queue.sv
hw/rtl/dlf_back.sv
hw/rtl/debug_link_framer_with_timeout_core.sv
hw/rtl/dlf_checker.sv
tb/tb.sv
